>>> rtl/mte_pkg.sv
// Shared types, codes and constants of the MIDI track event encoder.
package mte_pkg;

   typedef enum logic [2:0] {
      OP_NOTE_OFF       = 3'd0,
      OP_NOTE_ON        = 3'd1,
      OP_KEY_PRESSURE   = 3'd2,
      OP_CONTROL_CHANGE = 3'd3,
      OP_PROGRAM_CHANGE = 3'd4,
      OP_PITCH_BEND     = 3'd5
   } op_type;

   localparam logic [7:0] STATUS_NOTE_OFF       = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON        = 8'h90;
   localparam logic [7:0] STATUS_KEY_PRESSURE   = 8'hA0;
   localparam logic [7:0] STATUS_CONTROL_CHANGE = 8'hB0;
   localparam logic [7:0] STATUS_PROGRAM_CHANGE = 8'hC0;
   localparam logic [7:0] STATUS_PITCH_BEND     = 8'hE0;
   localparam logic [7:0] DATA_MASK             = 8'h7F;

   localparam int MAX_BYTES   = 7;
   localparam int VLQ_MAX     = 4;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [2:0] byte_idx_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      byte_idx_type              count;
   } evt_type;

   function automatic logic [7:0] status_of(input op_type op);
      logic [7:0] s;
      unique case (op)
         OP_NOTE_OFF:       s = STATUS_NOTE_OFF;
         OP_NOTE_ON:        s = STATUS_NOTE_ON;
         OP_KEY_PRESSURE:   s = STATUS_KEY_PRESSURE;
         OP_CONTROL_CHANGE: s = STATUS_CONTROL_CHANGE;
         OP_PROGRAM_CHANGE: s = STATUS_PROGRAM_CHANGE;
         OP_PITCH_BEND:     s = STATUS_PITCH_BEND;
         default:           s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/mte_front.sv
// Front end: accepts events, tracks running status and builds the byte record.
module mte_front (
   input  logic          clock,
   input  logic          reset,
   input  logic [2:0]    req_operation,
   input  logic [3:0]    req_channel,
   input  logic [6:0]    req_data_first,
   input  logic [6:0]    req_data_second,
   input  logic [13:0]   req_bend_value,
   input  logic [27:0]   req_delta_ticks,
   input  logic          accept,
   output logic          evt_push,
   output mte_pkg::evt_type evt
);
   import mte_pkg::*;

   logic [7:0]   running_status_ff;
   logic [7:0]   running_status_in;
   logic [7:0]   status;
   logic         op_ok;
   logic         emit_status;
   byte_idx_type vlq_cnt;
   byte_idx_type k;
   op_type       op;
   logic [VLQ_MAX-1:0][6:0] grp_bits;

   assign op          = op_type'(req_operation);
   assign op_ok       = req_operation <= OP_PITCH_BEND;
   assign status      = status_of(op) | {4'h0, req_channel};
   assign emit_status = status != running_status_ff;
   assign evt_push    = accept && op_ok;
   assign grp_bits    = req_delta_ticks;

   always_comb begin
      logic [1:0] grp;
      grp = '0;
      priority if (req_delta_ticks[27:21] != 7'd0) vlq_cnt = 3'd4;
      else if (req_delta_ticks[27:14] != 14'd0)    vlq_cnt = 3'd3;
      else if (req_delta_ticks[27:7] != 21'd0)     vlq_cnt = 3'd2;
      else                                         vlq_cnt = 3'd1;
      evt.bytes = '0;
      for (int i = 0; i < VLQ_MAX; i++) begin
         if (byte_idx_type'(i) < vlq_cnt) begin
            grp = 2'(vlq_cnt - 3'd1 - byte_idx_type'(i));
            evt.bytes[i] = {byte_idx_type'(i) != (vlq_cnt - 3'd1), grp_bits[grp]};
         end
      end
      k = vlq_cnt;
      if (emit_status) begin
         evt.bytes[k] = status;
         k = k + 3'd1;
      end
      if (op == OP_PITCH_BEND) begin
         evt.bytes[k] = {1'b0, req_bend_value[6:0]};
         k = k + 3'd1;
         evt.bytes[k] = {1'b0, req_bend_value[13:7]};
         k = k + 3'd1;
      end else if (op == OP_PROGRAM_CHANGE) begin
         evt.bytes[k] = {1'b0, req_data_first};
         k = k + 3'd1;
      end else begin
         evt.bytes[k] = {1'b0, req_data_first};
         k = k + 3'd1;
         evt.bytes[k] = {1'b0, req_data_second};
         k = k + 3'd1;
      end
      evt.count = k;
   end

   assign running_status_in = evt_push ? status : running_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= 8'h00;
      end else begin
         running_status_ff <= running_status_in;
      end
   end

endmodule

>>> rtl/mte_queue.sv
// Short queue of event records between the front and back ends.
module mte_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mte_pkg::evt_type push_data,
   input  logic             q_pop,
   output logic             q_full,
   output logic             q_valid,
   output mte_pkg::evt_type q_data
);
   import mte_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   evt_type           slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff, wr_in;
   logic [PW-1:0]     rd_ff, rd_in;
   logic [PW:0]       cnt_ff, cnt_in;

   assign q_full  = cnt_ff == (PW+1)'(QUEUE_DEPTH);
   assign q_valid = cnt_ff != '0;
   assign q_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !q_pop) cnt_in = cnt_ff + 1'b1;
      else if (q_pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push || q_pop)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

>>> rtl/mte_back.sv
// Back end: serializes event records into the byte stream, one byte per transfer.
module mte_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  mte_pkg::evt_type q_data,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte
);
   import mte_pkg::*;

   evt_type      cur_ff, cur_in;
   byte_idx_type idx_ff, idx_in;
   logic         valid_ff, valid_in;
   logic         xfer;
   logic         last;

   assign empty         = !valid_ff;
   assign xfer          = valid_ff && pop;
   assign last          = idx_ff == (cur_ff.count - 3'd1);
   assign rsp_out_byte  = cur_ff.bytes[idx_ff];
   assign rsp_last_byte = last;
   assign q_pop         = q_valid && (!valid_ff || (xfer && last));

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (q_pop) begin
         cur_in   = q_data;
         idx_in   = '0;
         valid_in = 1'b1;
      end else if (xfer) begin
         if (last) valid_in = 1'b0;
         else idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> cur_ff.count >= 3'd2 && cur_ff.count <= 3'd7)
      else $error("record byte count out of range");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff < cur_ff.count)
      else $error("byte index past record end");
   a_mid_event_holds: assert property (@(posedge clock) disable iff (reset)
      xfer && !last |=> valid_ff && idx_ff == $past(idx_ff) + 3'd1)
      else $error("event dropped before its last byte");

endmodule

>>> rtl/midi_track_event_encoder.sv
// MIDI track event encoder top level.
// Each accepted event becomes 2 to 7 track bytes: a delta-time variable-length
// quantity of 1 to 4 bytes, the status byte when it differs from the running
// status, then one or two data bytes; the final byte of an event carries
// rsp_last_byte. Operation codes 6 and 7 are dropped and produce nothing.
// Bytes leave at one per cycle while pop is held; a two-record queue between the
// classifying front end and the serializing back end lets a new event be taken
// every cycle while the queue has room, and full rises only when both records
// wait.
module midi_track_event_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_operation,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_data_first,
   input  logic [6:0]  req_data_second,
   input  logic [13:0] req_bend_value,
   input  logic [27:0] req_delta_ticks,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);
   import mte_pkg::*;

   evt_type evt;
   evt_type q_data;
   logic    evt_push;
   logic    q_pop;
   logic    q_full;
   logic    q_valid;

   assign full = q_full;

   mte_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_channel     (req_channel),
      .req_data_first  (req_data_first),
      .req_data_second (req_data_second),
      .req_bend_value  (req_bend_value),
      .req_delta_ticks (req_delta_ticks),
      .accept          (push && !q_full),
      .evt_push        (evt_push),
      .evt             (evt)
   );

   mte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt),
      .q_pop     (q_pop),
      .q_full    (q_full),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   mte_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .pop           (pop),
      .empty         (empty),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
